// File: design/pncs_pkg.sv
`default_nettype none

package pncs_pkg;

	// Palette size: one cell of the search chain per entry.
	localparam int PALETTE_DEPTH = 8;

	// Field widths fixed by the interface.
	localparam int COLOR_W = 8;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 4;
	localparam int OUT_DIST_W = 23;

	// Internal widths.
	localparam int LUMA_W  = 8;
	localparam int OFF_W   = 9;
	localparam int DIFF_W  = 10;
	localparam int SQL_W   = 16;
	localparam int SQC_W   = 18;
	localparam int CHROMA_W = 20;
	localparam int DIST_W  = 24;
	localparam int WSUM_W  = 15;
	localparam int RECIP_W = 13;
	localparam int PROD_W  = WSUM_W + RECIP_W;

	// Luma weights and rounding term.
	localparam logic [WSUM_W-1:0] LUMA_WR    = WSUM_W'(30);
	localparam logic [WSUM_W-1:0] LUMA_WG    = WSUM_W'(59);
	localparam logic [WSUM_W-1:0] LUMA_WB    = WSUM_W'(11);
	localparam logic [WSUM_W-1:0] LUMA_ROUND = WSUM_W'(50);

	// Division by 100 as a multiply by 5243 / 2^19, exact for sums below 25600.
	localparam logic [RECIP_W-1:0] LUMA_RECIP = RECIP_W'(5243);
	localparam int LUMA_SHIFT = 19;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} pncs_cmd_t;

	// One item moving down the chain, with the running best match.
	typedef struct packed {
		pncs_cmd_t          cmd;
		logic [IDX_W-1:0]   slot;
		logic [LUMA_W-1:0]  luma;
		logic [OFF_W-1:0]   off_r;
		logic [OFF_W-1:0]   off_g;
		logic [OFF_W-1:0]   off_b;
		logic [IDX_W-1:0]   best_idx;
		logic [DIST_W-1:0]  best_dist;
	} pncs_token_t;

	// Static settings of one cell.
	typedef struct packed {
		logic [IDX_W-1:0] id;
		logic             active;
		logic             first;
	} pncs_cell_cfg_t;

endpackage

`default_nettype wire

// File: design/pncs_front.sv
`default_nettype none

module pncs_front
	import pncs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire logic               in_valid,
	input  wire logic               in_cmd,
	input  wire logic [IDX_W-1:0]   in_slot,
	input  wire logic [COLOR_W-1:0] in_red,
	input  wire logic [COLOR_W-1:0] in_green,
	input  wire logic [COLOR_W-1:0] in_blue,
	output logic                    out_valid,
	output pncs_token_t             out_tok
);

	logic               valid_s1;
	pncs_cmd_t          cmd_s1;
	logic [IDX_W-1:0]   slot_s1;
	logic [COLOR_W-1:0] red_s1;
	logic [COLOR_W-1:0] green_s1;
	logic [COLOR_W-1:0] blue_s1;
	logic [WSUM_W-1:0]  wsum_s1;
	logic [WSUM_W-1:0]  wsum;
	logic [PROD_W-1:0]  prod;
	logic [LUMA_W-1:0]  luma;
	logic               valid_s2;
	pncs_token_t        tok_s2;
	pncs_token_t        tok_next;

	// First stage: weighted channel sum including the rounding term.
	assign wsum = WSUM_W'(in_red) * LUMA_WR + WSUM_W'(in_green) * LUMA_WG
		+ WSUM_W'(in_blue) * LUMA_WB + LUMA_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= pncs_cmd_t'(in_cmd);
			slot_s1  <= in_slot;
			red_s1   <= in_red;
			green_s1 <= in_green;
			blue_s1  <= in_blue;
			wsum_s1  <= wsum;
		end
	end

	// Second stage: divide by 100 and take each channel's offset from luma.
	assign prod = PROD_W'(wsum_s1) * PROD_W'(LUMA_RECIP);
	assign luma = LUMA_W'(prod >> LUMA_SHIFT);

	always_comb begin
		tok_next.cmd       = cmd_s1;
		tok_next.slot      = slot_s1;
		tok_next.luma      = luma;
		tok_next.off_r     = OFF_W'(red_s1) - OFF_W'(luma);
		tok_next.off_g     = OFF_W'(green_s1) - OFF_W'(luma);
		tok_next.off_b     = OFF_W'(blue_s1) - OFF_W'(luma);
		tok_next.best_idx  = '0;
		tok_next.best_dist = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_tok   = tok_s2;

endmodule

`default_nettype wire

// File: design/pncs_cell.sv
`default_nettype none

module pncs_cell
	import pncs_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire pncs_cell_cfg_t cfg,
	input  wire logic           in_valid,
	input  wire pncs_token_t    in_tok,
	output logic                out_valid,
	output pncs_token_t         out_tok
);

	logic [LUMA_W-1:0]          ent_luma_q;
	logic [OFF_W-1:0]           ent_off_r_q;
	logic [OFF_W-1:0]           ent_off_g_q;
	logic [OFF_W-1:0]           ent_off_b_q;
	logic                       load_hit;
	logic signed [OFF_W-1:0]    dl;
	logic signed [DIFF_W-1:0]   dr;
	logic signed [DIFF_W-1:0]   dg;
	logic signed [DIFF_W-1:0]   db;
	logic signed [2*OFF_W-1:0]  pl;
	logic signed [2*DIFF_W-1:0] pr;
	logic signed [2*DIFF_W-1:0] pg;
	logic signed [2*DIFF_W-1:0] pb;
	logic                       valid_s1;
	pncs_token_t                tok_s1;
	logic [SQL_W-1:0]           sq_l_s1;
	logic [SQC_W-1:0]           sq_r_s1;
	logic [SQC_W-1:0]           sq_g_s1;
	logic [SQC_W-1:0]           sq_b_s1;
	logic [CHROMA_W-1:0]        chroma;
	logic [DIST_W-1:0]          cand_dist;
	logic                       take;
	logic                       valid_s2;
	pncs_token_t                tok_s2;
	pncs_token_t                tok_next;

	// A load claims this cell's entry as it passes; items behind it see the new color.
	assign load_hit = in_valid && (in_tok.cmd == CMD_LOAD) && (in_tok.slot == cfg.id);

	always_ff @(posedge clk) begin
		if (adv && load_hit) begin
			ent_luma_q  <= in_tok.luma;
			ent_off_r_q <= in_tok.off_r;
			ent_off_g_q <= in_tok.off_g;
			ent_off_b_q <= in_tok.off_b;
		end
	end

	// Stage one: differences and their squares.
	assign dl = $signed(OFF_W'(ent_luma_q)) - $signed(OFF_W'(in_tok.luma));
	assign dr = DIFF_W'($signed(ent_off_r_q)) - DIFF_W'($signed(in_tok.off_r));
	assign dg = DIFF_W'($signed(ent_off_g_q)) - DIFF_W'($signed(in_tok.off_g));
	assign db = DIFF_W'($signed(ent_off_b_q)) - DIFF_W'($signed(in_tok.off_b));
	assign pl = dl * dl;
	assign pr = dr * dr;
	assign pg = dg * dg;
	assign pb = db * db;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1  <= in_tok;
			sq_l_s1 <= pl[SQL_W-1:0];
			sq_r_s1 <= pr[SQC_W-1:0];
			sq_g_s1 <= pg[SQC_W-1:0];
			sq_b_s1 <= pb[SQC_W-1:0];
		end
	end

	// Stage two: weighted distance and the running minimum, earliest entry on ties.
	assign chroma    = CHROMA_W'(sq_r_s1) + CHROMA_W'(sq_g_s1) + CHROMA_W'(sq_b_s1);
	assign cand_dist = (DIST_W'(sq_l_s1) << 1) + (DIST_W'(chroma) << 3) + DIST_W'(chroma);
	assign take      = cfg.first || (cfg.active && (cand_dist < tok_s1.best_dist));

	always_comb begin
		tok_next = tok_s1;
		if (take) begin
			tok_next.best_idx  = cfg.id;
			tok_next.best_dist = cand_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s2 <= tok_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_tok   = tok_s2;

endmodule

`default_nettype wire

// File: design/palette_nearest_color_search.sv
// Channel   Direction  Handshake          Carries
// in        sink       in_valid/in_stall  cmd, entry_index, red, green, blue
// out       source     out_valid/out_stall best_index, match_distance
// cfg       sink       cfg_valid/cfg_ready entries_in_use
//
// One transaction is taken per clock while in_stall is low; a query's answer is registered through
// the two luma stages, the two stages in each of the eight palette cells and the output register.
// Reset clears every valid bit and sets entries_in_use to 8; palette colors hold whatever
// they held until loaded.
// While out_valid is high and out_stall is high the whole chain holds and in_stall is raised.
`default_nettype none

module palette_nearest_color_search
	import pncs_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  cmd,
	input  wire logic [IDX_W-1:0]      entry_index,
	input  wire logic [COLOR_W-1:0]    red,
	input  wire logic [COLOR_W-1:0]    green,
	input  wire logic [COLOR_W-1:0]    blue,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [IDX_W-1:0]           best_index,
	output logic [OUT_DIST_W-1:0]      match_distance,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_W-1:0]      entries_in_use
);

	logic              adv;
	logic [CFG_W-1:0]  entries_q;
	logic              chain_valid [PALETTE_DEPTH+1];
	pncs_token_t       chain_tok   [PALETTE_DEPTH+1];
	logic              out_valid_q;
	logic [IDX_W-1:0]  best_index_q;
	logic [OUT_DIST_W-1:0] match_distance_q;

	// The chain moves as one whenever the output register is free or being emptied.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;

	// The configuration register is always ready to take a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= CFG_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			entries_q <= entries_in_use;
		end
	end

	// Luma and channel offsets are worked out once, for loads and queries alike.
	pncs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_cmd    (cmd),
		.in_slot   (entry_index),
		.in_red    (red),
		.in_green  (green),
		.in_blue   (blue),
		.out_valid (chain_valid[0]),
		.out_tok   (chain_tok[0])
	);

	// One cell per palette entry. Cell zero always seeds the best match; a cell at or
	// beyond the number of entries in use passes the running best through unchanged.
	// A register value of zero still searches entry zero, and values above the depth
	// simply leave every cell active.
	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		pncs_cell_cfg_t cell_cfg;

		assign cell_cfg.id     = IDX_W'(i);
		assign cell_cfg.first  = (i == 0);
		assign cell_cfg.active = (i == 0) || (entries_q > CFG_W'(i));

		pncs_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cfg       (cell_cfg),
			.in_valid  (chain_valid[i]),
			.in_tok    (chain_tok[i]),
			.out_valid (chain_valid[i+1]),
			.out_tok   (chain_tok[i+1])
		);
	end

	// Only queries leave the chain as results; loads are dropped at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain_valid[PALETTE_DEPTH]
				&& (chain_tok[PALETTE_DEPTH].cmd == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			best_index_q     <= chain_tok[PALETTE_DEPTH].best_idx;
			match_distance_q <= chain_tok[PALETTE_DEPTH].best_dist[OUT_DIST_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign best_index     = best_index_q;
	assign match_distance = match_distance_q;

endmodule

`default_nettype wire

// File: design/pncs_checker.sv
`default_nettype none

module pncs_checker
	import pncs_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_stall,
	input wire logic                  out_valid,
	input wire logic                  out_stall,
	input wire logic [IDX_W-1:0]      best_index,
	input wire logic [OUT_DIST_W-1:0] match_distance
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(best_index) && $stable(match_distance))
		else $error("result changed while stalled");

	// Input back-pressure appears only when a finished result is itself held up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// The weighted distance never exceeds the bound set by the largest square of each term.
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_distance <= OUT_DIST_W'(7152750))
		else $error("distance out of range");

endmodule

bind palette_nearest_color_search pncs_checker u_pncs_checker (.*);

`default_nettype wire
